### design/plob_pkg.sv
// Shared types and constants of the price-level order book.
package plob_pkg;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_MODIFY = 3'd2;
    localparam logic [2:0] REQ_VEXEC  = 3'd3;
    localparam logic [2:0] REQ_QUERY  = 3'd4;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_NOLVL = 2'd2;
    localparam logic [1:0] ERR_FULL  = 2'd3;

    localparam logic SIDE_BUY = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [31:0] new_price;
        logic [31:0] new_quantity;
    } req_t;

    typedef struct packed {
        logic        bbo_changed;
        logic [31:0] bid_price;
        logic [31:0] bid_quantity;
        logic [31:0] ask_price;
        logic [31:0] ask_quantity;
        logic [31:0] level_quantity;
        logic [1:0]  error_code;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HELD_UPD,
        ST_MAIN_UPD,
        ST_ADD_UPD,
        ST_BBO_SCAN,
        ST_BBO_DONE,
        ST_OUT
    } eng_state_t;

endpackage

### design/plob_front.sv
// Input stage: takes request beats and queues them for the engine.
module plob_front #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  plob_pkg::req_t in_req,
    output logic           q_valid,
    input  logic           q_ready,
    output plob_pkg::req_t q_req
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    plob_pkg::req_t    mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;
    logic              push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_req;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    property p_bound;
        @(posedge aclk) disable iff (!aresetn)
            cnt_reg <= (AW+1)'(DEPTH);
    endproperty
    a_bound: assert property (p_bound) else $error("queue overflow");

    property p_pop_nonempty;
        @(posedge aclk) disable iff (!aresetn)
            pop |-> (cnt_reg != '0);
    endproperty
    a_pop_nonempty: assert property (p_pop_nonempty) else $error("queue empty but valid");

    property p_cnt;
        @(posedge aclk) disable iff (!aresetn)
            (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1);
    endproperty
    a_cnt: assert property (p_cnt) else $error("count did not advance");
endmodule

### design/plob_engine.sv
// Back end: walks the level tables to carry out one request at a time.
module plob_engine #(
    parameter int LEVELS_PER_SIDE = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  plob_pkg::req_t q_req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output plob_pkg::rsp_t rsp
);
    localparam int N  = 2 * LEVELS_PER_SIDE;
    localparam int IW = $clog2(LEVELS_PER_SIDE);
    localparam int AW = IW + 1;
    localparam int PB = PRICE_BITS;

    logic [PB-1:0] lp_mem [N];
    logic [31:0]   lq_mem [N];
    logic [PB-1:0] hp_mem [N];
    logic [31:0]   hq_mem [N];
    logic [N-1:0]  lv_reg, hv_reg;

    plob_pkg::eng_state_t st_reg, st_next;
    plob_pkg::req_t r_reg;
    logic [IW:0]   i_reg, i_next;
    logic [AW-1:0] rd_addr;
    logic [PB-1:0] lp_rd, hp_rd;
    logic [31:0]   lq_rd, hq_rd;
    logic          rd_ok_reg;
    logic [AW-1:0] rd_idx_reg;

    logic          mf_reg, hf_reg, nf_reg, lfree_f_reg, hfree_f_reg;
    logic [AW-1:0] mi_reg, hi_reg, ni_reg, lfree_reg, hfree_reg;
    logic [31:0]   mqty_reg, hqty_reg, nqty_reg;
    logic [31:0]   rem_reg;
    logic [1:0]    err_reg;
    logic          bb_have_reg, ba_have_reg;
    logic [PB-1:0] bbp_reg, bap_reg;
    logic [31:0]   bbq_reg, baq_reg;
    logic [31:0]   lbp_reg, lbq_reg, lap_reg, laq_reg;
    plob_pkg::rsp_t rsp_reg;

    logic [PB-1:0] p_ext, np_ext;
    logic [AW-1:0] base;

    function automatic logic [PB-1:0] ext(input logic [31:0] v);
        logic [PB+31:0] w;
        w = {{PB{v[31]}}, v};
        return w[PB-1:0];
    endfunction

    function automatic logic [31:0] lo32(input logic [PB-1:0] v);
        logic [PB+31:0] w;
        w = {{32{v[PB-1]}}, v};
        return w[31:0];
    endfunction

    function automatic logic [31:0] sadd(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign p_ext  = ext(r_reg.price);
    assign np_ext = ext(r_reg.new_price);
    assign base   = r_reg.side ? AW'(LEVELS_PER_SIDE) : '0;
    assign q_ready   = (st_reg == plob_pkg::ST_IDLE);
    assign rsp_valid = (st_reg == plob_pkg::ST_OUT);
    assign rsp       = rsp_reg;

    // Scan address: in table scans, index walks one side; in BBO scan, both sides.
    always_comb begin
        if (st_reg == plob_pkg::ST_BBO_SCAN) begin
            rd_addr = i_reg;
        end else begin
            rd_addr = base + AW'(i_reg[IW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        lp_rd <= lp_mem[rd_addr];
        lq_rd <= lq_mem[rd_addr];
        hp_rd <= hp_mem[rd_addr];
        hq_rd <= hq_mem[rd_addr];
    end

    always_comb begin
        st_next = st_reg;
        i_next  = i_reg;
        case (st_reg)
            plob_pkg::ST_IDLE: begin
                if (q_valid) begin
                    st_next = plob_pkg::ST_SCAN;
                    i_next  = '0;
                end
            end
            plob_pkg::ST_SCAN: begin
                if (i_reg != (IW+1)'(LEVELS_PER_SIDE)) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    st_next = plob_pkg::ST_HELD_UPD;
                end
            end
            plob_pkg::ST_HELD_UPD: st_next = plob_pkg::ST_MAIN_UPD;
            plob_pkg::ST_MAIN_UPD: begin
                if (r_reg.req_type == plob_pkg::REQ_MODIFY) begin
                    st_next = plob_pkg::ST_ADD_UPD;
                end else if (r_reg.req_type inside {plob_pkg::REQ_ADD,
                        plob_pkg::REQ_REMOVE, plob_pkg::REQ_VEXEC}) begin
                    st_next = plob_pkg::ST_BBO_SCAN;
                    i_next  = '0;
                end else begin
                    st_next = plob_pkg::ST_OUT;
                end
            end
            plob_pkg::ST_ADD_UPD: begin
                st_next = plob_pkg::ST_BBO_SCAN;
                i_next  = '0;
            end
            plob_pkg::ST_BBO_SCAN: begin
                if (i_reg != (IW+1)'(2 * LEVELS_PER_SIDE - 1)) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    st_next = plob_pkg::ST_BBO_DONE;
                end
            end
            plob_pkg::ST_BBO_DONE: st_next = plob_pkg::ST_OUT;
            plob_pkg::ST_OUT: begin
                if (rsp_ready) begin
                    st_next = plob_pkg::ST_IDLE;
                end
            end
            default: st_next = plob_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= plob_pkg::ST_IDLE;
            i_reg  <= '0;
        end else begin
            st_reg <= st_next;
            i_reg  <= i_next;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        logic [31:0] rem;
        logic [1:0]  err;
        logic        lv, hv;
        rem = rem_reg;
        err = err_reg;
        lv  = 1'b0;
        hv  = 1'b0;
        rd_idx_reg <= rd_addr;
        if (!aresetn) begin
            lv_reg  <= '0;
            hv_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            rd_ok_reg <= (st_reg == plob_pkg::ST_SCAN || st_reg == plob_pkg::ST_BBO_SCAN)
                         && (st_reg == plob_pkg::ST_BBO_SCAN
                             || i_reg != (IW+1)'(LEVELS_PER_SIDE));
            case (st_reg)
                plob_pkg::ST_IDLE: begin
                    if (q_valid) begin
                        r_reg       <= q_req;
                        mf_reg      <= 1'b0; hf_reg <= 1'b0; nf_reg <= 1'b0;
                        lfree_f_reg <= 1'b0; hfree_f_reg <= 1'b0;
                        rem_reg     <= q_req.quantity;
                        err_reg     <= plob_pkg::ERR_OK;
                        bb_have_reg <= 1'b0; ba_have_reg <= 1'b0;
                    end
                end
                plob_pkg::ST_SCAN: begin
                    if (rd_ok_reg) begin
                        lv = lv_reg[rd_idx_reg];
                        hv = hv_reg[rd_idx_reg];
                        if (lv && lp_rd == p_ext && !mf_reg) begin
                            mf_reg <= 1'b1; mi_reg <= rd_idx_reg; mqty_reg <= lq_rd;
                        end
                        if (lv && lp_rd == np_ext && !nf_reg) begin
                            nf_reg <= 1'b1; ni_reg <= rd_idx_reg; nqty_reg <= lq_rd;
                        end
                        if (hv && hp_rd == p_ext && !hf_reg) begin
                            hf_reg <= 1'b1; hi_reg <= rd_idx_reg; hqty_reg <= hq_rd;
                        end
                        if (!lv && !lfree_f_reg) begin
                            lfree_f_reg <= 1'b1; lfree_reg <= rd_idx_reg;
                        end
                        if (!hv && !hfree_f_reg) begin
                            hfree_f_reg <= 1'b1; hfree_reg <= rd_idx_reg;
                        end
                    end
                end
                plob_pkg::ST_HELD_UPD: begin
                    if (r_reg.req_type == plob_pkg::REQ_REMOVE
                            || r_reg.req_type == plob_pkg::REQ_MODIFY) begin
                        if (hf_reg) begin
                            if (hqty_reg > rem) begin
                                hq_mem[hi_reg] <= hqty_reg - rem;
                                rem = '0;
                            end else begin
                                rem = rem - hqty_reg;
                                hv_reg[hi_reg] <= 1'b0;
                            end
                        end
                    end else if (r_reg.req_type == plob_pkg::REQ_VEXEC) begin
                        if (hf_reg) begin
                            hq_mem[hi_reg] <= sadd(hqty_reg, r_reg.quantity);
                        end else if (hfree_f_reg) begin
                            hv_reg[hfree_reg] <= 1'b1;
                            hp_mem[hfree_reg] <= p_ext;
                            hq_mem[hfree_reg] <= r_reg.quantity;
                        end
                    end
                    rem_reg <= rem;
                end
                plob_pkg::ST_MAIN_UPD: begin
                    case (r_reg.req_type)
                        plob_pkg::REQ_ADD: begin
                            if (mf_reg) begin
                                lq_mem[mi_reg] <= sadd(mqty_reg, rem);
                            end else if (lfree_f_reg) begin
                                lv_reg[lfree_reg] <= 1'b1;
                                lp_mem[lfree_reg] <= p_ext;
                                lq_mem[lfree_reg] <= rem;
                            end else begin
                                err = plob_pkg::ERR_FULL;
                            end
                        end
                        plob_pkg::REQ_REMOVE, plob_pkg::REQ_MODIFY, plob_pkg::REQ_VEXEC: begin
                            if (rem != '0 || r_reg.req_type == plob_pkg::REQ_VEXEC) begin
                                if (!mf_reg) begin
                                    err = plob_pkg::ERR_NOLVL;
                                end else if (mqty_reg > rem) begin
                                    lq_mem[mi_reg] <= mqty_reg - rem;
                                    if (nf_reg && ni_reg == mi_reg) begin
                                        nqty_reg <= mqty_reg - rem;
                                    end
                                end else if (mqty_reg == rem) begin
                                    lv_reg[mi_reg] <= 1'b0;
                                    if (nf_reg && ni_reg == mi_reg) begin
                                        nf_reg <= 1'b0;
                                    end
                                    if (!lfree_f_reg || mi_reg < lfree_reg) begin
                                        lfree_f_reg <= 1'b1; lfree_reg <= mi_reg;
                                    end
                                end else begin
                                    err = plob_pkg::ERR_SHORT;
                                    if (r_reg.req_type == plob_pkg::REQ_REMOVE) begin
                                        lv_reg[mi_reg] <= 1'b0;
                                    end
                                end
                            end
                            if (r_reg.req_type == plob_pkg::REQ_VEXEC && !hf_reg
                                    && !hfree_f_reg) begin
                                err = plob_pkg::ERR_FULL;
                            end
                        end
                        default: ;
                    endcase
                    err_reg <= err;
                end
                plob_pkg::ST_ADD_UPD: begin
                    if (nf_reg) begin
                        lq_mem[ni_reg] <= sadd(nqty_reg, r_reg.new_quantity);
                    end else if (lfree_f_reg) begin
                        lv_reg[lfree_reg] <= 1'b1;
                        lp_mem[lfree_reg] <= np_ext;
                        lq_mem[lfree_reg] <= r_reg.new_quantity;
                    end else begin
                        err_reg <= plob_pkg::ERR_FULL;
                    end
                end
                plob_pkg::ST_BBO_SCAN, plob_pkg::ST_BBO_DONE: begin
                    if (rd_ok_reg && lv_reg[rd_idx_reg]) begin
                        if (rd_idx_reg >= AW'(LEVELS_PER_SIDE)) begin
                            if (!bb_have_reg || $signed(lp_rd) > $signed(bbp_reg)) begin
                                bb_have_reg <= 1'b1; bbp_reg <= lp_rd; bbq_reg <= lq_rd;
                            end
                        end else begin
                            if (!ba_have_reg || $signed(lp_rd) < $signed(bap_reg)) begin
                                ba_have_reg <= 1'b1; bap_reg <= lp_rd; baq_reg <= lq_rd;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // BBO_DONE still folds in the last scanned entry through a combinational view.
    logic        fin_bh, fin_ah;
    logic [PB-1:0] fin_bp, fin_ap;
    logic [31:0] fin_bq, fin_aq;
    always_comb begin
        fin_bh = bb_have_reg; fin_bp = bbp_reg; fin_bq = bbq_reg;
        fin_ah = ba_have_reg; fin_ap = bap_reg; fin_aq = baq_reg;
        if (rd_ok_reg && lv_reg[rd_idx_reg]) begin
            if (rd_idx_reg >= AW'(LEVELS_PER_SIDE)) begin
                if (!bb_have_reg || $signed(lp_rd) > $signed(bbp_reg)) begin
                    fin_bh = 1'b1; fin_bp = lp_rd; fin_bq = lq_rd;
                end
            end else if (!ba_have_reg || $signed(lp_rd) < $signed(bap_reg)) begin
                fin_ah = 1'b1; fin_ap = lp_rd; fin_aq = lq_rd;
            end
        end
    end

    logic [31:0] n_bp, n_bq, n_ap, n_aq;
    assign n_bp = fin_bh ? lo32(fin_bp) : '0;
    assign n_bq = fin_bh ? fin_bq : '0;
    assign n_ap = fin_ah ? lo32(fin_ap) : '0;
    assign n_aq = fin_ah ? fin_aq : '0;

    // Response register: BBO_DONE writes from the full scan; queries and unused request codes keep the old BBO.
    always_ff @(posedge aclk) begin
        if (st_reg == plob_pkg::ST_BBO_DONE) begin
            rsp_reg.bbo_changed    <= (n_bp != lbp_reg) || (n_bq != lbq_reg)
                                      || (n_ap != lap_reg) || (n_aq != laq_reg);
            rsp_reg.bid_price      <= n_bp;
            rsp_reg.bid_quantity   <= n_bq;
            rsp_reg.ask_price      <= n_ap;
            rsp_reg.ask_quantity   <= n_aq;
            rsp_reg.level_quantity <= '0;
            rsp_reg.error_code     <= err_reg;
        end else if (st_reg == plob_pkg::ST_MAIN_UPD && !(r_reg.req_type inside
                {plob_pkg::REQ_ADD, plob_pkg::REQ_REMOVE, plob_pkg::REQ_MODIFY,
                 plob_pkg::REQ_VEXEC})) begin
            rsp_reg.bbo_changed    <= 1'b0;
            rsp_reg.bid_price      <= lbp_reg;
            rsp_reg.bid_quantity   <= lbq_reg;
            rsp_reg.ask_price      <= lap_reg;
            rsp_reg.ask_quantity   <= laq_reg;
            rsp_reg.level_quantity <= (mf_reg && r_reg.req_type == plob_pkg::REQ_QUERY)
                                      ? mqty_reg : '0;
            rsp_reg.error_code     <= plob_pkg::ERR_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lbp_reg <= '0; lbq_reg <= '0; lap_reg <= '0; laq_reg <= '0;
        end else if (st_reg == plob_pkg::ST_BBO_DONE) begin
            lbp_reg <= n_bp; lbq_reg <= n_bq; lap_reg <= n_ap; laq_reg <= n_aq;
        end
    end

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
            (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_reg));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    property p_take;
        @(posedge aclk) disable iff (!aresetn)
            (q_valid && q_ready) |=> (st_reg == plob_pkg::ST_SCAN);
    endproperty
    a_take: assert property (p_take) else $error("request not started");

    property p_query_quiet;
        @(posedge aclk) disable iff (!aresetn)
            (rsp_valid && r_reg.req_type == plob_pkg::REQ_QUERY) |-> !rsp_reg.bbo_changed;
    endproperty
    a_query_quiet: assert property (p_query_quiet) else $error("query changed BBO");
endmodule

### design/price_level_order_book_bbo_core.sv
// Price-level order book top level. A request that changes the book holds the engine
// for one scan of the requested side's tables for the price and free slots and one
// scan of both main tables for the best bid and ask, one entry per cycle through a
// single read port; a modify adds one more update state, and a query or an unused
// request code makes only the first scan. A two-entry queue takes the next request
// while one runs.
module price_level_order_book_bbo_core #(
    parameter int LEVELS_PER_SIDE = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic        s_side,
    input  logic [31:0] s_price,
    input  logic [31:0] s_quantity,
    input  logic [31:0] s_new_price,
    input  logic [31:0] s_new_quantity,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_bbo_changed,
    output logic [31:0] m_bid_price,
    output logic [31:0] m_bid_quantity,
    output logic [31:0] m_ask_price,
    output logic [31:0] m_ask_quantity,
    output logic [31:0] m_level_quantity,
    output logic [1:0]  m_error_code
);
    plob_pkg::req_t in_req, q_req;
    plob_pkg::rsp_t rsp;
    logic q_valid, q_ready;

    assign in_req = '{req_type: s_req_type, side: s_side, price: s_price,
                      quantity: s_quantity, new_price: s_new_price,
                      new_quantity: s_new_quantity};

    plob_front #(.DEPTH(2)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    plob_engine #(.LEVELS_PER_SIDE(LEVELS_PER_SIDE), .PRICE_BITS(PRICE_BITS)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .rsp_valid(m_valid), .rsp_ready(m_ready), .rsp(rsp)
    );

    assign m_bbo_changed    = rsp.bbo_changed;
    assign m_bid_price      = rsp.bid_price;
    assign m_bid_quantity   = rsp.bid_quantity;
    assign m_ask_price      = rsp.ask_price;
    assign m_ask_quantity   = rsp.ask_quantity;
    assign m_level_quantity = rsp.level_quantity;
    assign m_error_code     = rsp.error_code;
endmodule

### dv/tb_top.sv
// Testbench for the price-level order book: random and directed requests checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLVL = 64;
    localparam int NUM_RANDOM = 1200;
    localparam longint CYCLE_LIMIT = 1500000;

    class book_scoreboard;
        logic [31:0] lvl_px[2*NLVL];
        logic [31:0] lvl_qty[2*NLVL];
        bit lvl_ok[2*NLVL];
        logic [31:0] hld_px[2*NLVL];
        logic [31:0] hld_qty[2*NLVL];
        bit hld_ok[2*NLVL];
        logic [31:0] prev_bid_px, prev_bid_qty, prev_ask_px, prev_ask_qty;
        plob_pkg::rsp_t pending_rsp[$];
        int mismatches;
        int checked;
        int err_seen[4];

        function void clear();
            foreach (lvl_ok[i]) begin
                lvl_ok[i] = 0;
                hld_ok[i] = 0;
            end
            prev_bid_px = 0;
            prev_bid_qty = 0;
            prev_ask_px = 0;
            prev_ask_qty = 0;
        endfunction

        function int find_level(bit held, bit sd, logic [31:0] p);
            int k;
            for (int i = 0; i < NLVL; i++) begin
                k = sd * NLVL + i;
                if (held ? (hld_ok[k] && hld_px[k] == p) : (lvl_ok[k] && lvl_px[k] == p))
                    return k;
            end
            return -1;
        endfunction

        function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [1:0] accumulate(bit held, bit sd, logic [31:0] p, logic [31:0] q);
            int k;
            k = find_level(held, sd, p);
            if (k >= 0) begin
                if (held) hld_qty[k] = sat_sum(hld_qty[k], q);
                else lvl_qty[k] = sat_sum(lvl_qty[k], q);
                return plob_pkg::ERR_OK;
            end
            for (int i = 0; i < NLVL; i++) begin
                k = sd * NLVL + i;
                if (held && !hld_ok[k]) begin
                    hld_ok[k] = 1;
                    hld_px[k] = p;
                    hld_qty[k] = q;
                    return plob_pkg::ERR_OK;
                end
                if (!held && !lvl_ok[k]) begin
                    lvl_ok[k] = 1;
                    lvl_px[k] = p;
                    lvl_qty[k] = q;
                    return plob_pkg::ERR_OK;
                end
            end
            return plob_pkg::ERR_FULL;
        endfunction

        function logic [1:0] withdraw(bit sd, logic [31:0] p, logic [31:0] q, bit clear_short);
            logic [31:0] rem;
            int h, m;
            rem = q;
            h = find_level(1, sd, p);
            if (h >= 0) begin
                if (hld_qty[h] > rem) begin
                    hld_qty[h] -= rem;
                    rem = 0;
                end else begin
                    rem -= hld_qty[h];
                    hld_ok[h] = 0;
                end
            end
            if (rem == 0) return plob_pkg::ERR_OK;
            m = find_level(0, sd, p);
            if (m < 0) return plob_pkg::ERR_NOLVL;
            if (lvl_qty[m] > rem) begin
                lvl_qty[m] -= rem;
                return plob_pkg::ERR_OK;
            end
            if (lvl_qty[m] == rem) begin
                lvl_ok[m] = 0;
                return plob_pkg::ERR_OK;
            end
            if (clear_short) lvl_ok[m] = 0;
            return plob_pkg::ERR_SHORT;
        endfunction

        function void note_request(plob_pkg::req_t r);
            plob_pkg::rsp_t e;
            logic [1:0] err, e2;
            int m;
            bit hb, ha;
            logic [31:0] bp, bq, ap, aq;
            err = plob_pkg::ERR_OK;
            e = '0;
            if (r.req_type <= plob_pkg::REQ_VEXEC) begin
                case (r.req_type)
                    plob_pkg::REQ_ADD: err = accumulate(0, r.side, r.price, r.quantity);
                    plob_pkg::REQ_REMOVE: err = withdraw(r.side, r.price, r.quantity, 1);
                    plob_pkg::REQ_MODIFY: begin
                        err = withdraw(r.side, r.price, r.quantity, 0);
                        e2 = accumulate(0, r.side, r.new_price, r.new_quantity);
                        if (e2 != plob_pkg::ERR_OK) err = e2;
                    end
                    default: begin
                        m = find_level(0, r.side, r.price);
                        if (m < 0) err = plob_pkg::ERR_NOLVL;
                        else if (lvl_qty[m] > r.quantity) lvl_qty[m] -= r.quantity;
                        else if (lvl_qty[m] == r.quantity) lvl_ok[m] = 0;
                        else err = plob_pkg::ERR_SHORT;
                        e2 = accumulate(1, r.side, r.price, r.quantity);
                        if (e2 != plob_pkg::ERR_OK) err = e2;
                    end
                endcase
                hb = 0;
                ha = 0;
                bp = 0;
                bq = 0;
                ap = 0;
                aq = 0;
                for (int i = 0; i < NLVL; i++) begin
                    if (lvl_ok[NLVL+i] && (!hb || $signed(lvl_px[NLVL+i]) > $signed(bp))) begin
                        hb = 1;
                        bp = lvl_px[NLVL+i];
                        bq = lvl_qty[NLVL+i];
                    end
                    if (lvl_ok[i] && (!ha || $signed(lvl_px[i]) < $signed(ap))) begin
                        ha = 1;
                        ap = lvl_px[i];
                        aq = lvl_qty[i];
                    end
                end
                e.bbo_changed = (bp != prev_bid_px) || (bq != prev_bid_qty) ||
                                (ap != prev_ask_px) || (aq != prev_ask_qty);
                prev_bid_px = bp;
                prev_bid_qty = bq;
                prev_ask_px = ap;
                prev_ask_qty = aq;
            end else if (r.req_type == plob_pkg::REQ_QUERY) begin
                m = find_level(0, r.side, r.price);
                if (m >= 0) e.level_quantity = lvl_qty[m];
            end
            e.bid_price = prev_bid_px;
            e.bid_quantity = prev_bid_qty;
            e.ask_price = prev_ask_px;
            e.ask_quantity = prev_ask_qty;
            e.error_code = err;
            err_seen[err]++;
            pending_rsp.push_back(e);
        endfunction

        function void check_response(plob_pkg::rsp_t got);
            plob_pkg::rsp_t e;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            e = pending_rsp.pop_front();
            checked++;
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d: expected %p, got %p", checked, e, got);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [2:0] s_req_type = '0;
    logic s_side = 0;
    logic [31:0] s_price = '0;
    logic [31:0] s_quantity = '0;
    logic [31:0] s_new_price = '0;
    logic [31:0] s_new_quantity = '0;
    logic m_valid;
    logic m_ready = 0;
    logic m_bbo_changed;
    logic [31:0] m_bid_price, m_bid_quantity, m_ask_price, m_ask_quantity;
    logic [31:0] m_level_quantity;
    logic [1:0] m_error_code;

    book_scoreboard book;
    longint cycles = 0;
    bit quiet = 0;
    logic [31:0] price_pool[8];

    always #2 aclk = ~aclk;

    price_level_order_book_bbo_core dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_response({m_bbo_changed, m_bid_price, m_bid_quantity, m_ask_price,
                                 m_ask_quantity, m_level_quantity, m_error_code});
    end

    always @(negedge aclk) begin
        if (aresetn) m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
    end

    task automatic send_request(plob_pkg::req_t r);
        while (!quiet && $urandom_range(99) < 17) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_req_type <= r.req_type;
        s_side <= r.side;
        s_price <= r.price;
        s_quantity <= r.quantity;
        s_new_price <= r.new_price;
        s_new_quantity <= r.new_quantity;
        do @(posedge aclk); while (!s_ready);
        book.note_request(r);
        @(negedge aclk);
    endtask

    task automatic send(logic [2:0] t, bit sd, logic [31:0] p, logic [31:0] q,
                        logic [31:0] np = 0, logic [31:0] nq = 0);
        plob_pkg::req_t r;
        r.req_type = t;
        r.side = sd;
        r.price = p;
        r.quantity = q;
        r.new_price = np;
        r.new_quantity = nq;
        send_request(r);
    endtask

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(9))
            0: return 32'hFFFF_FFFF - $urandom_range(3);
            1: return 0;
            2: return $urandom;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    function automatic logic [31:0] pick_price();
        return ($urandom_range(9) == 0) ? $urandom : price_pool[$urandom_range(7)];
    endfunction

    initial begin
        int wait_cnt;
        plob_pkg::req_t r;
        book = new();
        book.clear();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        m_ready <= 1;

        send(plob_pkg::REQ_ADD, plob_pkg::SIDE_BUY, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send(plob_pkg::REQ_ADD, plob_pkg::SIDE_BUY, 32'h7FFF_FFFF, 5);
        send(plob_pkg::REQ_ADD, 0, 32'h8000_0000, 0);
        send(plob_pkg::REQ_ADD, 0, 32'h0000_0010, 100);
        send(plob_pkg::REQ_QUERY, plob_pkg::SIDE_BUY, 32'h7FFF_FFFF, 0);
        send(plob_pkg::REQ_QUERY, 0, 32'h1234, 0);
        send(plob_pkg::REQ_VEXEC, 0, 32'h0000_0010, 30);
        send(plob_pkg::REQ_VEXEC, 0, 32'h0000_0011, 3);
        send(plob_pkg::REQ_VEXEC, 0, 32'h0000_0010, 500);
        send(plob_pkg::REQ_REMOVE, 0, 32'h0000_0010, 40);
        send(plob_pkg::REQ_MODIFY, 0, 32'h0000_0010, 1000, 32'hFFFF_FFF0, 9);
        send(plob_pkg::REQ_REMOVE, 0, 32'h0000_0077, 1);
        send(plob_pkg::REQ_REMOVE, 0, 32'hFFFF_FFF0, 50);
        send(3'd5, plob_pkg::SIDE_BUY, 32'h7FFF_FFFF, 0);
        send(3'd7, 0, 0, 0);
        for (int i = 0; i < 66; i++) send(plob_pkg::REQ_ADD, 0, 32'h100 + i, 1);
        send(plob_pkg::REQ_MODIFY, 0, 32'h100, 1, 32'h999, 4);
        for (int i = 0; i < 66; i++) send(plob_pkg::REQ_REMOVE, 0, 32'h100 + i, 1);

        for (int blk = 0; blk < 20; blk++) begin
            foreach (price_pool[i]) price_pool[i] = $urandom_range(0, 40) - 20;
            if (blk % 5 == 0) foreach (price_pool[i]) price_pool[i] = $urandom;
            quiet = (blk == 7);
            for (int n = 0; n < NUM_RANDOM / 20; n++) begin
                r.req_type = ($urandom_range(15) == 0) ? 3'($urandom_range(7))
                                                       : 3'($urandom_range(4));
                r.side = 1'($urandom_range(1));
                r.price = pick_price();
                r.quantity = pick_qty();
                r.new_price = pick_price();
                r.new_quantity = pick_qty();
                send_request(r);
            end
        end
        quiet = 0;
        s_valid <= 0;

        wait_cnt = 0;
        while (book.pending_rsp.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (300) @(posedge aclk);
        $display("checked %0d results; errors seen ok/short/nolevel/full: %0d/%0d/%0d/%0d",
                 book.checked, book.err_seen[0], book.err_seen[1], book.err_seen[2],
                 book.err_seen[3]);
        if (book.mismatches == 0 && book.pending_rsp.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", book.mismatches,
                     book.pending_rsp.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### filelist.f
design/plob_pkg.sv
design/plob_front.sv
design/plob_engine.sv
design/price_level_order_book_bbo_core.sv
dv/tb_top.sv
